FILE: hw/rtl/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types and codes for the arm hook sequencer: request and response
// payloads, step and drive codes, register indexes and the sequencer state.
// ----------------------------------------------------------------------------
package ahs_pkg;

   // sequence step codes
   localparam logic [2:0] STEP_RAISE_VERT = 3'd0;
   localparam logic [2:0] STEP_EXTEND     = 3'd1;
   localparam logic [2:0] STEP_RAISE_PAST = 3'd2;
   localparam logic [2:0] STEP_RETRACT    = 3'd3;
   localparam logic [2:0] STEP_LOWER      = 3'd4;
   localparam logic [2:0] STEP_DONE       = 3'd5;

   // pivot motor commands
   localparam logic [1:0] PIVOT_STOP  = 2'd0;
   localparam logic [1:0] PIVOT_RAISE = 2'd1;
   localparam logic [1:0] PIVOT_LOWER = 2'd2;

   // extension motor commands
   localparam logic [1:0] EXT_STOP    = 2'd0;
   localparam logic [1:0] EXT_EXTEND  = 2'd1;
   localparam logic [1:0] EXT_RETRACT = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTICAL    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_RAISE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINCH_START = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] VERTICAL_RESET    = 16'd44;
   localparam logic [CSR_DATA_W-1:0] FULL_RAISE_RESET  = 16'd54;
   localparam logic [CSR_DATA_W-1:0] WINCH_START_RESET = 16'd29;

   typedef struct packed {
      logic [15:0] pulse_count;
      logic        extend_out_limit;
      logic        extend_in_limit;
      logic        raise_low_limit;
      logic        restart;
   } ahs_req_type;

   typedef struct packed {
      logic [2:0]         step_code;
      logic [1:0]         pivot_drive;
      logic [1:0]         extend_drive;
      logic               winch_drive;
      logic               clear_counter;
      logic signed [31:0] arm_position;
   } ahs_rsp_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] vertical_count;
      logic [CSR_DATA_W-1:0] full_raise_count;
      logic [CSR_DATA_W-1:0] winch_start_count;
   } ahs_cfg_type;

   typedef struct packed {
      logic [2:0]  step;
      logic        moving_reverse;
      logic [31:0] position_base;
      logic [1:0]  pivot_cmd;
      logic [1:0]  extend_cmd;
      logic        winch_cmd;
   } ahs_state_type;

endpackage

FILE: hw/rtl/ahs_step.sv
// ----------------------------------------------------------------------------
// ahs_step
// One sequencer tick: from the held state, the registers and one request,
// form the next state and the response. Purely combinational.
// ----------------------------------------------------------------------------
module ahs_step (
   input  ahs_pkg::ahs_state_type state_cur,
   input  ahs_pkg::ahs_cfg_type   cfg,
   input  ahs_pkg::ahs_req_type   req,
   output ahs_pkg::ahs_state_type state_nxt,
   output ahs_pkg::ahs_rsp_type   rsp
);
   import ahs_pkg::*;

   logic [31:0] count_ext;
   logic [31:0] position;
   logic [15:0] raise_limit;
   logic        reached_raise;
   logic        winch_zone;
   logic        clear_req;

   // position before any direction change; direction changes only rebase it
   assign count_ext = {16'd0, req.pulse_count};
   assign position  = state_cur.moving_reverse ? state_cur.position_base - count_ext
                                               : state_cur.position_base + count_ext;

   // signed position against unsigned 16-bit thresholds
   assign raise_limit   = (state_cur.step == STEP_RAISE_VERT) ? cfg.vertical_count
                                                              : cfg.full_raise_count;
   assign reached_raise = !position[31] && (position >= {16'd0, raise_limit});
   assign winch_zone    = position[31] || (position <= {16'd0, cfg.winch_start_count});

   // step logic
   always_comb begin
      state_nxt = state_cur;
      clear_req = 1'b0;
      if (req.restart) begin
         state_nxt.step = STEP_RAISE_VERT;
      end else begin
         case (state_cur.step)
            STEP_RAISE_VERT, STEP_RAISE_PAST: begin
               if (state_cur.moving_reverse) begin
                  state_nxt.position_base  = position;
                  state_nxt.moving_reverse = 1'b0;
                  clear_req                = 1'b1;
               end
               if (reached_raise) begin
                  state_nxt.pivot_cmd = PIVOT_STOP;
                  state_nxt.step      = state_cur.step + 3'd1;
               end else begin
                  state_nxt.pivot_cmd = PIVOT_RAISE;
               end
            end
            STEP_EXTEND: begin
               if (req.extend_out_limit) begin
                  state_nxt.extend_cmd = EXT_STOP;
                  state_nxt.step       = STEP_RAISE_PAST;
               end else begin
                  state_nxt.extend_cmd = EXT_EXTEND;
               end
            end
            STEP_RETRACT: begin
               if (req.extend_in_limit) begin
                  state_nxt.extend_cmd = EXT_STOP;
                  state_nxt.step       = STEP_LOWER;
               end else begin
                  state_nxt.extend_cmd = EXT_RETRACT;
               end
            end
            STEP_LOWER: begin
               if (req.raise_low_limit) begin
                  // lower then stop in one tick: the second rebase always flips back
                  state_nxt.position_base  = position;
                  state_nxt.moving_reverse = 1'b0;
                  state_nxt.pivot_cmd      = PIVOT_STOP;
                  state_nxt.winch_cmd      = 1'b0;
                  state_nxt.step           = STEP_DONE;
                  clear_req                = 1'b1;
               end else begin
                  if (!state_cur.moving_reverse) begin
                     state_nxt.position_base  = position;
                     state_nxt.moving_reverse = 1'b1;
                     clear_req                = 1'b1;
                  end
                  state_nxt.pivot_cmd = PIVOT_LOWER;
                  if (winch_zone) begin
                     state_nxt.winch_cmd = 1'b1;
                  end
               end
            end
            default: begin
               // done and unused codes hold everything
            end
         endcase
      end
   end

   // response fields
   assign rsp.step_code     = state_nxt.step;
   assign rsp.pivot_drive   = state_nxt.pivot_cmd;
   assign rsp.extend_drive  = state_nxt.extend_cmd;
   assign rsp.winch_drive   = state_nxt.winch_cmd;
   assign rsp.clear_counter = clear_req;
   assign rsp.arm_position  = position;

endmodule

FILE: hw/rtl/arm_hook_sequencer_top.sv
// Responses are registered: one is valid in the cycle after its acceptance.
// Throughput: one request per cycle when not stalled; the single tick logic
// sits between the held sequencer state and the response register.
// Requests are taken while the response register is empty or draining.
// Reset (synchronous, active high) returns the step to raise-to-vertical,
// stops all drives, zeroes the position base and reloads register defaults.
// ----------------------------------------------------------------------------
// arm_hook_sequencer_top
// Six-step arm and winch sequencer with direction-corrected pivot position
// from a direction-blind encoder count.
// ----------------------------------------------------------------------------
module arm_hook_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ahs_pkg::ahs_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ahs_pkg::ahs_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [ahs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ahs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ahs_pkg::*;

   ahs_cfg_type   cfg_ff;
   ahs_state_type state_ff;
   ahs_state_type state_in;
   ahs_rsp_type   rsp_data_ff;
   ahs_rsp_type   rsp_data_in;
   logic          rsp_valid_ff;
   logic          req_accept;

   // handshake: stall only while a response is held and not taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertical_count    <= VERTICAL_RESET;
         cfg_ff.full_raise_count  <= FULL_RAISE_RESET;
         cfg_ff.winch_start_count <= WINCH_START_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTICAL:    cfg_ff.vertical_count    <= csr_wdata;
            CSR_FULL_RAISE:  cfg_ff.full_raise_count  <= csr_wdata;
            CSR_WINCH_START: cfg_ff.winch_start_count <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // tick logic
   ahs_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .req       (req_data),
      .state_nxt (state_in),
      .rsp       (rsp_data_in)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.step           <= STEP_RAISE_VERT;
         state_ff.moving_reverse <= 1'b0;
         state_ff.position_base  <= 32'd0;
         state_ff.pivot_cmd      <= PIVOT_STOP;
         state_ff.extend_cmd     <= EXT_STOP;
         state_ff.winch_cmd      <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.step <= STEP_DONE)
      else $error("step left the valid range");

   a_reverse_tracks_pivot: assert property (@(posedge clock) disable iff (reset)
      state_ff.moving_reverse == (state_ff.pivot_cmd == PIVOT_LOWER))
      else $error("direction flag out of step with pivot command");

   a_clear_rebases: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (!rsp_data_ff.clear_counter
                      || state_ff.position_base == rsp_data_ff.arm_position))
      else $error("counter clear without matching position base");

endmodule
